[hdl/orbit_camera_basis_macros.svh]
// Assertion macros for the checker file.
`ifndef ORBIT_CAMERA_BASIS_MACROS_SVH
`define ORBIT_CAMERA_BASIS_MACROS_SVH

// Check a consequence on the next clock, also while reset is applied.
`define OCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("orbit_camera_basis check failed");

// Check a consequence on the next clock, ignored during reset.
`define OCB_ASSERT_NEXT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orbit_camera_basis check failed");

`endif

[hdl/ocb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocb_pkg
// Types, constants and the arctangent table of the orbit camera basis block.
// ----------------------------------------------------------------------------
package ocb_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW                = 35;  // CORDIC datapath width, Q2.30 plus headroom

  localparam logic signed [15:0]   PITCH_LIMIT  = 16'sd16373;
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 35'sd652032874;
  localparam logic [31:0]          MIN_RADIUS_RST = 32'd6554;
  localparam logic [31:0]          MAX_RADIUS_RST = 32'd65536000;

  typedef logic [0:0] cfg_addr_t;
  localparam cfg_addr_t REG_MIN_RADIUS = 1'd0;
  localparam cfg_addr_t REG_MAX_RADIUS = 1'd1;

  typedef struct packed {
    logic [15:0]        yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic [31:0]        orbit_radius;
  } item_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
      21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

[hdl/orbit_camera_basis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_camera_basis
// Orbit camera forward/right/up basis and position from yaw, pitch, pivot and
// radius.
// ----------------------------------------------------------------------------
// One word is taken per cycle while the queue is not full, and one result
// leaves per cycle while pop is high. Once a word leaves the four-word input
// queue it passes the back pipeline registers (fold, one per CORDIC rotation,
// rounding, basis products, radius products, position); the pipelined CORDIC
// sets the rate. While a result waits with pop low the back pipeline holds and
// the queue keeps taking words until it is full. Radius registers are written
// through cfg_we/cfg_addr/cfg_data: index 0 min_radius, index 1 max_radius.
module orbit_camera_basis import ocb_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_addr_t   cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  item_t       item,
  input  logic        pop,
  output logic        empty,
  output result_t     result
);

  item_t clamped;
  item_t head;
  logic  head_valid;
  logic  head_take;

  ocb_front u_front (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .item, .clamped
  );

  ocb_queue u_queue (
    .clk, .rst,
    .wr        (push && !full),
    .wr_data   (clamped),
    .rd        (head_take),
    .rd_data   (head),
    .full,
    .not_empty (head_valid)
  );

  ocb_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk, .rst,
    .src_valid (head_valid),
    .src       (head),
    .src_take  (head_take),
    .pop,
    .empty,
    .result
  );

endmodule

[hdl/ocb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocb_front
// Holds the radius range registers and clamps pitch and radius of each word.
// ----------------------------------------------------------------------------
module ocb_front import ocb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_addr_t cfg_addr,
  input  logic [31:0] cfg_data,
  input  item_t     item,
  output item_t     clamped
);

  logic [31:0] min_radius;
  logic [31:0] max_radius;
  logic [31:0] radius_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_radius <= MIN_RADIUS_RST;
      max_radius <= MAX_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_RADIUS: min_radius <= cfg_data;
        REG_MAX_RADIUS: max_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    clamped = item;
    if (item.pitch_angle > PITCH_LIMIT) clamped.pitch_angle = PITCH_LIMIT;
    else if (item.pitch_angle < -PITCH_LIMIT) clamped.pitch_angle = -PITCH_LIMIT;
    // raise to min first, max wins on an inverted range
    radius_lo = (item.orbit_radius < min_radius) ? min_radius : item.orbit_radius;
    clamped.orbit_radius = (radius_lo > max_radius) ? max_radius : radius_lo;
  end

endmodule

[hdl/ocb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocb_queue
// Four-word queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module ocb_queue import ocb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_data,
  input  logic  rd,
  output item_t rd_data,
  output logic  full,
  output logic  not_empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  item_t           mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ocb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocb_back
// Pipelined CORDIC sine/cosine, basis products and position, with the result
// register at the end. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module ocb_back import ocb_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  input  item_t   src,
  output logic    src_take,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  localparam int N = CORDIC_STAGES;
  localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  function automatic cord_t prep(input logic [15:0] ang, output logic flip);
    logic [31:0] a;
    logic signed [CW-1:0] z;
    cord_t c;
    a = {ang, 16'h0} & KEEP_MASK;
    z = CW'($signed(a));
    flip = 1'b0;
    if (z > 35'sd1073741824) begin
      z = z - 35'sd2147483648;
      flip = 1'b1;
    end else if (z < -35'sd1073741824) begin
      z = z + 35'sd2147483648;
      flip = 1'b1;
    end
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.z = z;
    return c;
  endfunction

  function automatic cord_t rotate(input cord_t c, input int k);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    cord_t r;
    dx = c.y >>> k;
    dy = c.x >>> k;
    at = $signed({3'b000, atan_turn(k)});
    if (!c.z[CW-1]) begin
      r.x = c.x - dx; r.y = c.y + dy; r.z = c.z - at;
    end else begin
      r.x = c.x + dx; r.y = c.y - dy; r.z = c.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v,
                                                input logic neg);
    logic signed [CW-1:0] t;
    t = ((neg ? -v : v) + 35'sd32768) >>> 16;
    if (t > 35'sd16384) t = 35'sd16384;
    else if (t < -35'sd16384) t = -35'sd16384;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [32:0] p;
    p = 33'(a * b) + 33'sd8192;
    p = p >>> 14;
    return p[15:0];
  endfunction

  function automatic logic signed [31:0] place(input logic signed [31:0] pv,
                                               input logic signed [49:0] fr);
    logic signed [51:0] v;
    v = (52'(pv) <<< 14) - 52'(fr) + 52'sd8192;
    v = v >>> 14;
    if (v > 52'sd2147483647) v = 52'sd2147483647;
    else if (v < -52'sd2147483648) v = -52'sd2147483648;
    return v[31:0];
  endfunction

  logic adv;
  logic out_valid;

  assign adv      = !out_valid || pop;
  assign src_take = adv && src_valid;
  assign empty    = !out_valid;

  // CORDIC chain: index 0 is the folded angle, index N the last rotation
  cord_t yc    [N+1];
  cord_t pc    [N+1];
  logic  yflip [N+1];
  logic  pflip [N+1];
  item_t side  [N+1];
  logic  cv    [N+1];

  cord_t yc0, pc0;
  logic  yf0, pf0;

  always_comb begin
    yc0 = prep(src.yaw_angle, yf0);
    pc0 = prep(src.pitch_angle, pf0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yc[0]    <= yc0;
      pc[0]    <= pc0;
      yflip[0] <= yf0;
      pflip[0] <= pf0;
      side[0]  <= src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= src_valid;
  end

  for (genvar k = 0; k < N; k++) begin : g_cord
    always_ff @(posedge clk) begin
      if (adv) begin
        yc[k+1]    <= rotate(yc[k], k);
        pc[k+1]    <= rotate(pc[k], k);
        yflip[k+1] <= yflip[k];
        pflip[k+1] <= pflip[k];
        side[k+1]  <= side[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else if (adv) cv[k+1] <= cv[k];
    end
  end

  // round stage
  logic signed [15:0] cy, sy, cp, sp;
  item_t side_r;
  logic  rv;

  always_ff @(posedge clk) begin
    if (adv) begin
      cy     <= to_q14(yc[N].x, yflip[N]);
      sy     <= to_q14(yc[N].y, yflip[N]);
      cp     <= to_q14(pc[N].x, pflip[N]);
      sp     <= to_q14(pc[N].y, pflip[N]);
      side_r <= side[N];
    end
  end

  // product stage
  result_t vec;
  item_t   side_m;
  logic    mv;

  always_ff @(posedge clk) begin
    if (adv) begin
      vec.fwd_x   <= -mul14(sy, cp);
      vec.fwd_y   <= sp;
      vec.fwd_z   <= -mul14(cy, cp);
      vec.right_x <= cy;
      vec.right_z <= -sy;
      vec.up_x    <= mul14(sy, sp);
      vec.up_y    <= cp;
      vec.up_z    <= mul14(cy, sp);
      vec.pos_x   <= '0;
      vec.pos_y   <= '0;
      vec.pos_z   <= '0;
      side_m      <= side_r;
    end
  end

  // forward times radius
  result_t            vec_f;
  item_t              side_f;
  logic signed [49:0] frx, fry, frz;
  logic               fv;
  logic signed [32:0] rad;

  assign rad = $signed({1'b0, side_m.orbit_radius});

  always_ff @(posedge clk) begin
    if (adv) begin
      frx    <= 50'(vec.fwd_x * rad);
      fry    <= 50'(vec.fwd_y * rad);
      frz    <= 50'(vec.fwd_z * rad);
      vec_f  <= vec;
      side_f <= side_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv        <= 1'b0;
      mv        <= 1'b0;
      fv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      rv        <= cv[N];
      mv        <= rv;
      fv        <= mv;
      out_valid <= fv;
    end
  end

  result_t res_d;

  always_comb begin
    res_d       = vec_f;
    res_d.pos_x = place(side_f.pivot_x, frx);
    res_d.pos_y = place(side_f.pivot_y, fry);
    res_d.pos_z = place(side_f.pivot_z, frz);
  end

  always_ff @(posedge clk) begin
    if (adv) result <= res_d;
  end

endmodule

[hdl/ocb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocb_checker
// Port-level checks of the orbit camera basis block, bound to the top level.
// ----------------------------------------------------------------------------
`include "orbit_camera_basis_macros.svh"

module ocb_checker import ocb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    pop,
  input logic    empty,
  input result_t result
);

  `OCB_ASSERT_NEXT(a_empty_after_rst, rst, empty)
  `OCB_ASSERT_NEXT(a_room_after_rst, rst, !full)
  `OCB_ASSERT_NEXT_RUN(a_result_kept, !empty && !pop, !empty)
  `OCB_ASSERT_NEXT_RUN(a_result_held, !empty && !pop, $stable(result))

endmodule

bind orbit_camera_basis ocb_checker u_ocb_checker (
  .clk, .rst, .full, .pop, .empty, .result
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_camera_basis testbench
// Drives yaw/pitch/pivot/radius words through the queue ports under several
// idle patterns and radius settings, and checks each basis and position word
// against a CORDIC-exact predictor kept in the bench, or a typed expectation.
// ----------------------------------------------------------------------------
module testbench;
  import ocb_pkg::*;

  localparam int LATENCY   = 40;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 430;
  localparam logic [31:0] Q30_GAIN = 32'd652032874;
  localparam int PLIM = 16373;

  logic clk, rst;
  logic cfg_we;
  cfg_addr_t cfg_addr;
  logic [31:0] cfg_data;
  logic push, full, pop, empty;
  item_t item;
  result_t result;

  orbit_camera_basis u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .push(push), .full(full), .item(item), .pop(pop), .empty(empty), .result(result)
  );

  logic [31:0] rmin, rmax;
  result_t pending_basis[$];
  int errors, n_sent, n_checked, cycles;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint fdiv(longint v, int s);
    return v >>> s;  // arithmetic shift on longint is a floor
  endfunction

  function automatic longint to_q14(longint v);
    longint r;
    r = fdiv(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return fdiv(a * b + 8192, 14);
  endfunction

  task automatic rotate(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    logic [31:0] a;
    a = {ang, 16'h0};
    z = longint'($signed(a));
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    x = Q30_GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fdiv(y, i);
      dy = fdiv(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = to_q14(x);
    s = to_q14(y);
  endtask

  function automatic logic [31:0] place(logic signed [31:0] p, longint f, longint r);
    longint v;
    v = fdiv(longint'(p) * 16384 - f * r + 8192, 14);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_basis(input item_t it, output result_t e);
    longint p, r, cy, sy, cp, sp, fx, fz;
    logic [31:0] rad;
    p = longint'(it.pitch_angle);
    if (p > PLIM) p = PLIM;
    if (p < -PLIM) p = -PLIM;
    rad = it.orbit_radius;
    if (rad < rmin) rad = rmin;
    if (rad > rmax) rad = rmax;
    r = longint'({32'h0, rad});
    rotate(it.yaw_angle, cy, sy);
    rotate(p[15:0], cp, sp);
    fx = -rmul(sy, cp);
    fz = -rmul(cy, cp);
    e.fwd_x = fx[15:0];
    e.fwd_y = sp[15:0];
    e.fwd_z = fz[15:0];
    e.right_x = cy[15:0];
    e.right_z = 16'(-sy);
    e.up_x = 16'(rmul(sy, sp));
    e.up_y = cp[15:0];
    e.up_z = 16'(rmul(cy, sp));
    e.pos_x = place(it.pivot_x, fx, r);
    e.pos_y = place(it.pivot_y, sp, r);
    e.pos_z = place(it.pivot_z, fz, r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch word %0d %s: got %0d expected %0d", n_checked, what, got, want);
  endtask

  // result side: pop at random, sample at the rising edge
  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_basis.size() == 0) begin
        errors++;
        $display("unexpected result word");
      end else begin
        result_t e;
        e = pending_basis.pop_front();
        if (result.fwd_x !== e.fwd_x) report("fwd_x", result.fwd_x, e.fwd_x);
        if (result.fwd_y !== e.fwd_y) report("fwd_y", result.fwd_y, e.fwd_y);
        if (result.fwd_z !== e.fwd_z) report("fwd_z", result.fwd_z, e.fwd_z);
        if (result.right_x !== e.right_x) report("right_x", result.right_x, e.right_x);
        if (result.right_z !== e.right_z) report("right_z", result.right_z, e.right_z);
        if (result.up_x !== e.up_x) report("up_x", result.up_x, e.up_x);
        if (result.up_y !== e.up_y) report("up_y", result.up_y, e.up_y);
        if (result.up_z !== e.up_z) report("up_z", result.up_z, e.up_z);
        if (result.pos_x !== e.pos_x) report("pos_x", result.pos_x, e.pos_x);
        if (result.pos_y !== e.pos_y) report("pos_y", result.pos_y, e.pos_y);
        if (result.pos_z !== e.pos_z) report("pos_z", result.pos_z, e.pos_z);
        n_checked++;
      end
    end
  end

  // Send one word; use the typed expectation when one is given.
  task automatic send(input item_t it, input bit typed, input result_t want);
    result_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    if (typed) e = want;
    else predict_basis(it, e);
    item <= it;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_basis.push_back(e);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_addr_t a, input logic [31:0] d);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
    if (a == REG_MIN_RADIUS) rmin = d;
    else rmax = d;
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 0;
    while (pending_basis.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.yaw_angle = 16'($urandom);
    case ($urandom_range(3))
      0: it.pitch_angle = 16'($urandom);
      1: it.pitch_angle = 16'($signed($urandom_range(2 * PLIM)) - PLIM);
      2: it.pitch_angle = $urandom_range(1) ? 16'sd16373 : -16'sd16373;
      default: it.pitch_angle = 16'($signed($urandom_range(400)) - 200);
    endcase
    if ($urandom_range(3) == 0) begin
      it.pivot_x = $urandom; it.pivot_y = $urandom; it.pivot_z = $urandom;
    end else begin
      it.pivot_x = $signed($urandom) >>> 8;
      it.pivot_y = $signed($urandom) >>> 8;
      it.pivot_z = $signed($urandom) >>> 8;
    end
    it.orbit_radius = $urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000);
    return it;
  endfunction

  typedef struct {
    item_t it;
    bit typed;
    result_t want;
  } stim_row_t;

  function automatic item_t mk(logic [15:0] yaw, logic [15:0] pit,
                               logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] rad);
    item_t it;
    it.yaw_angle = yaw; it.pitch_angle = pit;
    it.pivot_x = px; it.pivot_y = py; it.pivot_z = pz; it.orbit_radius = rad;
    return it;
  endfunction

  stim_row_t rows[$];
  result_t none;

  initial begin
    int phase_len;
    stim_row_t row;
    result_t t0;
    errors = 0; n_sent = 0; n_checked = 0;
    hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    rst = 1; cfg_we = 0; cfg_addr = REG_MIN_RADIUS; cfg_data = 0;
    push = 0; item = '0; none = '0;
    rmin = MIN_RADIUS_RST; rmax = MAX_RADIUS_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // straight ahead, zero pivot, radius 1.0: looks down -Z, sits at +Z
    t0 = '0;
    t0.fwd_z = -16'sd16384; t0.right_x = 16'sd16384; t0.up_y = 16'sd16384;
    t0.pos_z = 32'sd65536;
    row.it = mk(16'h0, 16'h0, 0, 0, 0, 32'h10000); row.typed = 1; row.want = t0;
    rows.push_back(row);
    row.typed = 0; row.want = none;
    row.it = mk(16'hFFFF, 16'h7FFF, 32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF);
    rows.push_back(row);
    row.it = mk(16'h8000, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
    rows.push_back(row);
    row.it = mk(16'h4000, 16'd16373, 0, 32'h7FFFFFFF, 0, 32'h03E80000); rows.push_back(row);
    row.it = mk(16'hC000, -16'sd16373, 0, 32'h80000000, 0, 32'h03E80000);
    rows.push_back(row);
    row.it = mk(16'h2000, 16'd16374, 1, 2, 3, 32'd6553); rows.push_back(row);
    row.it = mk(16'h6000, -16'sd16374, -1, -2, -3, 32'd6554); rows.push_back(row);
    row.it = mk(16'hA000, 16'h4000, 32'h12345678, 0, 0, 32'd65536001); rows.push_back(row);
    row.it = mk(16'h5555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h5555AAAA, 32'hAAAA5555);
    rows.push_back(row);
    row.it = mk(16'h0001, 16'h0001, 32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000, 32'hFFFFFFFF);
    rows.push_back(row);
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].want);
    drain();

    // inverted range, then the extremes of both registers
    write_reg(REG_MIN_RADIUS, 32'hFFFFFFFF);
    write_reg(REG_MAX_RADIUS, 32'h00010000);
    repeat (6) send(rand_item(), 0, none);
    drain();
    write_reg(REG_MIN_RADIUS, 0);
    write_reg(REG_MAX_RADIUS, 32'hFFFFFFFF);
    repeat (6) send(rand_item(), 0, none);
    drain();

    phase_len = N_RANDOM / 5;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        // hold the receiver off long enough for the input to back up
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int k = 0; k < phase_len; k++) send(rand_item(), 0, none);
      drain();
      case (ph)
        0: begin write_reg(REG_MIN_RADIUS, $urandom); write_reg(REG_MAX_RADIUS, $urandom); end
        1: begin write_reg(REG_MIN_RADIUS, 32'd6554); write_reg(REG_MAX_RADIUS, 32'd65536000); end
        2: write_reg(REG_MIN_RADIUS, $urandom_range(32'h0010_0000));
        default: ;
      endcase
    end

    $display("sent %0d words, checked %0d, over several radius ranges and idle patterns",
             n_sent, n_checked);
    if (errors == 0 && pending_basis.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors, pending_basis.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[orbit_camera_basis.f]
+incdir+hdl
hdl/ocb_pkg.sv
hdl/ocb_front.sv
hdl/ocb_queue.sv
hdl/ocb_back.sv
hdl/orbit_camera_basis.sv
hdl/ocb_checker.sv
bench/testbench.sv
